// ===== sv/ilq_pkg.sv =====
// ----------------------------------------------------------------------------
// Indexed linked queue package
// Shared widths, node constants, operation and status codes, sequencer states.
// ----------------------------------------------------------------------------
package ilq_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int NODE_W   = $clog2(CAPACITY + 2);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int CAP_W    = 9;

  // Node 0 is the head sentinel, node CAPACITY+1 the tail sentinel
  localparam logic [NODE_W-1:0] HEAD_NODE = '0;
  localparam logic [NODE_W-1:0] TAIL_NODE = NODE_W'(CAPACITY + 1);

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PULL = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DUP    = 3'd1,
    ST_ABSENT = 3'd2,
    ST_EMPTY  = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ENQ_TAIL,
    S_UNLINK,
    S_FINISH
  } state_e;

endpackage

// ===== sv/ilq_in_if.sv =====
// ----------------------------------------------------------------------------
// Indexed linked queue request channel
// Valid/ready channel carrying one queue operation and its index.
// ----------------------------------------------------------------------------
interface ilq_in_if;
  logic                      valid;
  logic                      ready;
  ilq_pkg::op_e              operation;
  logic [ilq_pkg::IDX_W-1:0] item_index;

  modport source (output valid, operation, item_index, input ready);
  modport sink   (input valid, operation, item_index, output ready);
endinterface

// ===== sv/ilq_out_if.sv =====
// ----------------------------------------------------------------------------
// Indexed linked queue result channel
// Valid/ready channel carrying the removed index, status and queue summary.
// ----------------------------------------------------------------------------
interface ilq_out_if;
  logic                      valid;
  logic                      ready;
  logic [ilq_pkg::IDX_W-1:0] returned_index;
  ilq_pkg::status_e          status;
  logic [ilq_pkg::IDX_W-1:0] head_index;
  logic [ilq_pkg::IDX_W-1:0] tail_index;
  logic [ilq_pkg::CNT_W-1:0] item_count;
  logic                      is_empty;

  modport source (output valid, returned_index, status, head_index, tail_index,
                  item_count, is_empty, input ready);
  modport sink   (input valid, returned_index, status, head_index, tail_index,
                  item_count, is_empty, output ready);
endinterface

// ===== sv/ilq_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Indexed linked queue configuration channel
// Valid/ready write channel for the capacity register.
// ----------------------------------------------------------------------------
interface ilq_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ilq_pkg::CAP_W-1:0] capacity_in_use;

  modport source (output valid, capacity_in_use, input ready);
  modport sink   (input valid, capacity_in_use, output ready);
endinterface

// ===== sv/indexed_linked_queue_core.sv =====
// ----------------------------------------------------------------------------
// Indexed linked queue core
// FIFO order over small indices kept as a doubly linked list in two link RAMs.
// ----------------------------------------------------------------------------
// Sequence: idle, decode, then the tail step for an enqueue or the unlink step
//   for a dequeue or pull, then finish; errors and no-ops go straight to finish.
// Requests: a new one is taken only in idle, after the last result is loaded;
//   the steps are set by the single write port of each link RAM and its registered read.
// Reset: queue empty, capacity 256. Present bits live in flops and clear at
//   once; the link RAMs need no clearing pass, a link is only read once set.
module indexed_linked_queue_core (
  input  logic clk_i,
  input  logic rst_ni,
  ilq_in_if.sink    in_s,
  ilq_out_if.source out_s,
  ilq_cfg_if.sink   cfg_s
);
  import ilq_pkg::*;

  // Sequencer and request registers
  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  status_e             status_q, status_d;
  logic [IDX_W-1:0]    ret_q, ret_d;

  // Queue state: sentinel links kept in flops, node links in RAM
  logic [CAP_W-1:0]    cap_q, cap_d;
  logic [NODE_W-1:0]   head_q, head_d;   // head sentinel's next
  logic [NODE_W-1:0]   tail_q, tail_d;   // tail sentinel's prev
  logic [CAPACITY-1:0] present_q, present_d;
  logic [CNT_W-1:0]    count_q, count_d;

  // Link RAMs, one entry per index
  logic [NODE_W-1:0]   prev_mem [CAPACITY];
  logic [NODE_W-1:0]   next_mem [CAPACITY];
  logic [NODE_W-1:0]   rd_prev_q, rd_next_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                prev_we, next_we;
  logic [IDX_W-1:0]    prev_waddr, next_waddr;
  logic [NODE_W-1:0]   prev_wdata, next_wdata;

  // Result register
  logic                out_valid_q, out_valid_d;
  logic [IDX_W-1:0]    out_ret_q, out_head_q, out_tail_q;
  status_e             out_status_q;
  logic [CNT_W-1:0]    out_count_q;
  logic                out_empty_q;
  logic                out_load;

  // Decode of the held request
  logic                in_xfer, cfg_xfer;
  logic                in_range, enq_ok, deq_ok, pull_ok;
  logic [NODE_W-1:0]   idx_node;

  assign in_xfer  = in_s.valid && in_s.ready;
  assign cfg_xfer = cfg_s.valid && cfg_s.ready;

  assign in_s.ready  = (state_q == S_IDLE);
  assign cfg_s.ready = 1'b1;

  // Index must sit below the effective capacity (clipped at CAPACITY)
  assign in_range = (cap_q >= CAP_W'(CAPACITY)) || (CAP_W'(idx_q) < cap_q);
  assign enq_ok   = (op_q == OP_ENQ) && in_range && !present_q[idx_q];
  assign deq_ok   = (op_q == OP_DEQ) && (count_q != '0);
  assign pull_ok  = (op_q == OP_PULL) && in_range && present_q[idx_q];
  assign idx_node = NODE_W'(idx_q) + NODE_W'(1);

  // Dequeue reads the node behind the head sentinel, pull the given one
  assign rd_addr  = (op_q == OP_DEQ) ? IDX_W'(head_q - NODE_W'(1)) : idx_q;

  assign out_load = (state_q == S_FINISH) && (!out_valid_q || out_s.ready);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        priority if (enq_ok) begin
          state_d = S_ENQ_TAIL;
        end else if (deq_ok || pull_ok) begin
          state_d = S_UNLINK;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_ENQ_TAIL: state_d = S_FINISH;
      S_UNLINK:   state_d = S_FINISH;
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath control: link RAM writes and queue state updates
  always_comb begin
    op_d        = op_q;
    idx_d       = idx_q;
    status_d    = status_q;
    ret_d       = ret_q;
    cap_d       = cap_q;
    head_d      = head_q;
    tail_d      = tail_q;
    present_d   = present_q;
    count_d     = count_q;
    prev_we     = 1'b0;
    next_we     = 1'b0;
    prev_waddr  = '0;
    next_waddr  = '0;
    prev_wdata  = '0;
    next_wdata  = '0;
    out_valid_d = out_valid_q;

    // Drop the held result once it has been transferred
    if (out_s.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          op_d  = in_s.operation;
          idx_d = in_s.item_index;
        end
      end
      S_DECODE: begin
        status_d = ST_OK;
        ret_d    = '0;
        unique case (op_q)
          OP_ENQ: begin
            priority if (!in_range) begin
              status_d = ST_RANGE;
            end else if (present_q[idx_q]) begin
              status_d = ST_DUP;
            end else begin
              // Hook the new node behind the current last one
              prev_we    = 1'b1;
              prev_waddr = idx_q;
              prev_wdata = tail_q;
              if (tail_q == HEAD_NODE) begin
                head_d = idx_node;
              end else begin
                next_we    = 1'b1;
                next_waddr = IDX_W'(tail_q - NODE_W'(1));
                next_wdata = idx_node;
              end
              tail_d             = idx_node;
              present_d[idx_q]   = 1'b1;
              count_d            = count_q + CNT_W'(1);
            end
          end
          OP_DEQ: begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
            end else begin
              idx_d = rd_addr;
            end
          end
          OP_PULL: begin
            priority if (!in_range) begin
              status_d = ST_RANGE;
            end else if (!present_q[idx_q]) begin
              status_d = ST_ABSENT;
            end
          end
          OP_NOP: begin
          end
          default: begin
          end
        endcase
      end
      S_ENQ_TAIL: begin
        // Close the new node towards the tail sentinel
        next_we    = 1'b1;
        next_waddr = idx_q;
        next_wdata = TAIL_NODE;
      end
      S_UNLINK: begin
        // Splice the neighbours of the target node together
        ret_d            = idx_q;
        present_d[idx_q] = 1'b0;
        count_d          = count_q - CNT_W'(1);
        if (rd_prev_q == HEAD_NODE) begin
          head_d = rd_next_q;
        end else begin
          next_we    = 1'b1;
          next_waddr = IDX_W'(rd_prev_q - NODE_W'(1));
          next_wdata = rd_next_q;
        end
        if (rd_next_q == TAIL_NODE) begin
          tail_d = rd_prev_q;
        end else begin
          prev_we    = 1'b1;
          prev_waddr = IDX_W'(rd_next_q - NODE_W'(1));
          prev_wdata = rd_prev_q;
        end
      end
      S_FINISH: begin
        if (out_load) begin
          out_valid_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // A capacity write empties the queue; the source must send it only while idle, the block does not enforce it
    if (cfg_xfer) begin
      cap_d     = cfg_s.capacity_in_use;
      present_d = '0;
      count_d   = '0;
      head_d    = TAIL_NODE;
      tail_d    = HEAD_NODE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cap_q       <= CAP_W'(CAPACITY);
      head_q      <= TAIL_NODE;
      tail_q      <= HEAD_NODE;
      present_q   <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cap_q       <= cap_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      present_q   <= present_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request payload and result payload
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    idx_q    <= idx_d;
    status_q <= status_d;
    ret_q    <= ret_d;
    if (out_load) begin
      out_ret_q    <= ret_q;
      out_status_q <= status_q;
      out_head_q   <= (count_q != '0) ? IDX_W'(head_q - NODE_W'(1)) : '0;
      out_tail_q   <= (count_q != '0) ? IDX_W'(tail_q - NODE_W'(1)) : '0;
      out_count_q  <= count_q;
      out_empty_q  <= (count_q == '0);
    end
  end

  // Link RAMs: one write port each, registered read in decode
  always_ff @(posedge clk_i) begin
    if (prev_we) begin
      prev_mem[prev_waddr] <= prev_wdata;
    end
    if (next_we) begin
      next_mem[next_waddr] <= next_wdata;
    end
    if (state_q == S_DECODE) begin
      rd_prev_q <= prev_mem[rd_addr];
      rd_next_q <= next_mem[rd_addr];
    end
  end

  assign out_s.valid          = out_valid_q;
  assign out_s.returned_index = out_ret_q;
  assign out_s.status         = out_status_q;
  assign out_s.head_index     = out_head_q;
  assign out_s.tail_index     = out_tail_q;
  assign out_s.item_count     = out_count_q;
  assign out_s.is_empty       = out_empty_q;

`ifndef SYNTH
  // Count tracks membership
  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q == CNT_W'($countones(present_q)))
    else $error("item count differs from present bits");

  // Empty list has both sentinels pointing at each other
  a_empty_links: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == TAIL_NODE && tail_q == HEAD_NODE))
    else $error("empty queue with dangling sentinel links");

  // Only a present node is ever unlinked
  a_unlink_present: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UNLINK) |-> present_q[idx_q])
    else $error("unlink of an absent index");

  // A result is loaded only from the finishing step
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == S_FINISH)
    else $error("result raised outside the finishing step");
`endif

endmodule
